/* rtl/pcie_tlp_dword_requester_macros.svh */
// ----------------------------------------------------------------------------
// pcie_tlp_dword_requester_macros
// Assertion shorthands for the PCIe dword requester checkers. Each macro
// expects signals named clock and reset in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef PCIE_TLP_DWORD_REQUESTER_MACROS_SVH
`define PCIE_TLP_DWORD_REQUESTER_MACROS_SVH

// same-cycle implication
`define PTDR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PTDR_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ptdr_pkg.sv */
// ----------------------------------------------------------------------------
// ptdr_pkg
// Shared codes, job descriptor and helper functions of the PCIe dword
// requester.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptdr_pkg;

   localparam int MAX_PACKET_DWORDS_DEF = 1024;
   localparam int QUEUE_DEPTH_DEF       = 4;

   localparam int RX_COUNT_W = 11;
   localparam int LEN_W      = 11;
   localparam int BEAT_W     = 3;
   localparam int CSR_ADDR_W = 3;

   // request types
   localparam logic [1:0] REQ_MEM_WRITE = 2'd0;
   localparam logic [1:0] REQ_MEM_READ  = 2'd1;
   localparam logic [1:0] REQ_RX_DWORD  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_TX        = 2'd0;
   localparam logic [1:0] KIND_READ_DATA = 2'd1;
   localparam logic [1:0] KIND_ERROR     = 2'd2;

   // status codes
   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_MISALIGNED = 2'd1;
   localparam logic [1:0] STATUS_BAD_CPL    = 2'd2;

   // job opcodes between front and back
   localparam logic [1:0] OP_WRITE    = 2'd0;
   localparam logic [1:0] OP_READ     = 2'd1;
   localparam logic [1:0] OP_MISALIGN = 2'd2;
   localparam logic [1:0] OP_RX       = 2'd3;

   // TLP header type bytes
   localparam logic [7:0] HDR_TYPE_MEM_WRITE  = 8'h60;
   localparam logic [7:0] HDR_TYPE_MEM_READ   = 8'h20;
   localparam logic [7:0] HDR_TYPE_COMPLETION = 8'h4A;

   localparam logic [15:0] BYTE_ENABLES  = 16'h00ff;
   localparam logic [23:0] HDR_LENGTH_ONE = 24'h000001;

   localparam logic [BEAT_W-1:0] LAST_BEAT_READ  = 3'd3;
   localparam logic [BEAT_W-1:0] LAST_BEAT_WRITE = 3'd4;

   localparam logic [RX_COUNT_W-1:0] MIN_CPL_DWORDS = 11'd4;

   // register index, taken from paddr above the byte offset
   localparam logic [CSR_ADDR_W-3:0] CSR_REQUESTER_ID = 1'b0;

   typedef struct packed {
      logic [1:0]       op;
      logic [63:0]      address;
      logic [31:0]      data;
      logic [LEN_W-1:0] rx_length;
      logic             bad;
   } job_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   function automatic logic [31:0] swap_bytes(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   function automatic logic [LEN_W-1:0] size_from_header(input logic [31:0] hdr);
      logic [LEN_W-1:0] len;
      len = {1'b0, hdr[9:0]};
      case (hdr[30:29])
         2'd0:    return 11'd3;
         2'd1:    return 11'd4;
         2'd2:    return 11'd3 + len;
         default: return 11'd4 + len;
      endcase
   endfunction

endpackage

/* rtl/ptdr_channel_if.sv */
// ----------------------------------------------------------------------------
// ptdr_channel_if
// Valid/ready channels of the PCIe dword requester: request in, result out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ptdr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [63:0] address;
   logic [31:0] write_data;
   logic [31:0] rx_dword;
   logic        rx_last;

   modport source (output valid, req_type, address, write_data, rx_dword, rx_last,
                   input ready);
   modport sink   (input valid, req_type, address, write_data, rx_dword, rx_last,
                   output ready);
endinterface

interface ptdr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [31:0] tx_dword;
   logic [31:0] read_data;
   logic [10:0] rx_length_dwords;
   logic [1:0]  status;
   logic        last_of_run;

   modport source (output valid, result_kind, tx_dword, read_data, rx_length_dwords,
                   status, last_of_run, input ready);
   modport sink   (input valid, result_kind, tx_dword, read_data, rx_length_dwords,
                   status, last_of_run, output ready);
endinterface

/* rtl/ptdr_queue.sv */
// ----------------------------------------------------------------------------
// ptdr_queue
// Short job queue between the classifying front and the emitting back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptdr_queue
   import ptdr_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type q_status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   job_type          slots_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == LAST_SLOT) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[tail_ff] <= push_job;
      end
   end

   assign head_job       = slots_ff[head_ff];
   assign q_status.valid = (count_ff != '0);
   assign q_status.full  = (count_ff == FULL_CNT);

endmodule

/* rtl/ptdr_front.sv */
// ----------------------------------------------------------------------------
// ptdr_front
// Accepts requests and received dwords, tracks the receive TLP and turns
// each item into a job for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptdr_front
   import ptdr_pkg::*;
#(
   parameter int MAX_PACKET_DWORDS = MAX_PACKET_DWORDS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   ptdr_req_if.sink         req_chan,
   input  queue_status_type q_status,
   output logic             push,
   output job_type          push_job
);

   localparam logic [RX_COUNT_W-1:0] COUNT_LIMIT = RX_COUNT_W'(MAX_PACKET_DWORDS);

   logic [RX_COUNT_W-1:0] rx_count_ff, rx_count_in;
   logic [31:0]           rx_header_ff, rx_header_in;
   logic [31:0]           rx_payload_ff, rx_payload_in;
   logic                  accept;
   logic                  count_ok;
   logic [RX_COUNT_W-1:0] count_next;

   assign req_chan.ready = !q_status.full;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      count_ok      = (rx_count_ff < COUNT_LIMIT);
      rx_header_in  = rx_header_ff;
      rx_payload_in = rx_payload_ff;
      count_next    = rx_count_ff;
      // drop dwords past the limit, still honor the last mark
      if (count_ok) begin
         if (rx_count_ff == 11'd0) begin
            rx_header_in = req_chan.rx_dword;
         end else if (rx_count_ff == 11'd3) begin
            rx_payload_in = req_chan.rx_dword;
         end
         count_next = rx_count_ff + 1'b1;
      end
      rx_count_in = req_chan.rx_last ? '0 : count_next;

      push              = 1'b0;
      push_job.op       = OP_RX;
      push_job.address  = req_chan.address;
      push_job.data     = swap_bytes(req_chan.write_data);
      push_job.rx_length = '0;
      push_job.bad      = 1'b0;
      case (req_chan.req_type)
         REQ_MEM_WRITE, REQ_MEM_READ: begin
            push = accept;
            if (req_chan.address[1:0] != 2'b00) begin
               push_job.op = OP_MISALIGN;
            end else if (req_chan.req_type == REQ_MEM_WRITE) begin
               push_job.op = OP_WRITE;
            end else begin
               push_job.op = OP_READ;
            end
         end
         REQ_RX_DWORD: begin
            push               = accept && req_chan.rx_last;
            push_job.op        = OP_RX;
            push_job.data      = swap_bytes(rx_payload_in);
            push_job.rx_length = size_from_header(rx_header_in);
            push_job.bad       = (rx_header_in[31:24] != HDR_TYPE_COMPLETION) ||
                                 (count_next < MIN_CPL_DWORDS);
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_count_ff   <= '0;
         rx_header_ff  <= '0;
         rx_payload_ff <= '0;
      end else if (accept && (req_chan.req_type == REQ_RX_DWORD)) begin
         rx_count_ff   <= rx_count_in;
         rx_header_ff  <= rx_header_in;
         rx_payload_ff <= rx_payload_in;
      end
   end

endmodule

/* rtl/ptdr_back.sv */
// ----------------------------------------------------------------------------
// ptdr_back
// Pops jobs and emits their result dwords, one per cycle while the result
// channel is not stalled, through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptdr_back
   import ptdr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [15:0]      requester_id,
   input  queue_status_type q_status,
   input  job_type          head_job,
   output logic             pop,
   ptdr_rsp_if.source       rsp_chan
);

   job_type           job_ff;
   logic              active_ff, active_in;
   logic [BEAT_W-1:0] beat_ff, beat_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        kind_ff;
   logic [31:0]       tx_ff;
   logic [31:0]       rd_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [1:0]        status_ff;
   logic              last_ff;

   logic              out_free;
   logic              emit;
   logic              done;
   logic [1:0]        beat_kind;
   logic [31:0]       beat_tx;
   logic [31:0]       beat_rd;
   logic [LEN_W-1:0]  beat_len;
   logic [1:0]        beat_status;
   logic              beat_last;
   logic [7:0]        hdr_type;

   always_comb begin
      hdr_type    = (job_ff.op == OP_WRITE) ? HDR_TYPE_MEM_WRITE : HDR_TYPE_MEM_READ;
      beat_kind   = KIND_TX;
      beat_tx     = '0;
      beat_rd     = '0;
      beat_len    = '0;
      beat_status = STATUS_OK;
      beat_last   = 1'b1;
      case (job_ff.op)
         OP_WRITE, OP_READ: begin
            case (beat_ff)
               3'd0:    beat_tx = {hdr_type, HDR_LENGTH_ONE};
               3'd1:    beat_tx = {requester_id, BYTE_ENABLES};
               3'd2:    beat_tx = job_ff.address[63:32];
               3'd3:    beat_tx = job_ff.address[31:0];
               default: beat_tx = job_ff.data;
            endcase
            beat_last = (job_ff.op == OP_WRITE) ? (beat_ff == LAST_BEAT_WRITE)
                                                : (beat_ff == LAST_BEAT_READ);
         end
         OP_MISALIGN: begin
            beat_kind   = KIND_ERROR;
            beat_status = STATUS_MISALIGNED;
         end
         default: begin
            beat_len = job_ff.rx_length;
            if (job_ff.bad) begin
               beat_kind   = KIND_ERROR;
               beat_status = STATUS_BAD_CPL;
            end else begin
               beat_kind = KIND_READ_DATA;
               beat_rd   = job_ff.data;
            end
         end
      endcase
   end

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_chan.ready;
      emit         = active_ff && out_free;
      done         = emit && beat_last;
      // take the next job in the same cycle the current one finishes
      pop          = q_status.valid && (!active_ff || done);
      active_in    = pop ? 1'b1 : (done ? 1'b0 : active_ff);
      beat_in      = pop ? '0 : (emit ? beat_ff + 1'b1 : beat_ff);
      rsp_valid_in = emit ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         beat_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head_job;
      end
      if (emit) begin
         kind_ff   <= beat_kind;
         tx_ff     <= beat_tx;
         rd_ff     <= beat_rd;
         len_ff    <= beat_len;
         status_ff <= beat_status;
         last_ff   <= beat_last;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.result_kind      = kind_ff;
   assign rsp_chan.tx_dword         = tx_ff;
   assign rsp_chan.read_data        = rd_ff;
   assign rsp_chan.rx_length_dwords = len_ff;
   assign rsp_chan.status           = status_ff;
   assign rsp_chan.last_of_run      = last_ff;

endmodule

/* rtl/pcie_tlp_dword_requester.sv */
// ----------------------------------------------------------------------------
// pcie_tlp_dword_requester: PCIe one-dword MWr64/MRd64 requester and CplD receiver
// Path: request queued (accepted while the queue is not full), job register, output register.
// Output: one dword per cycle unless stalled; write 5 dwords, read 4, error or completion 1.
// Reset: synchronous, clears queue, receive count and requester id; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcie_tlp_dword_requester
   import ptdr_pkg::*;
#(
   parameter int MAX_PACKET_DWORDS = MAX_PACKET_DWORDS_DEF,
   parameter int QUEUE_DEPTH       = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ptdr_req_if.sink              req_chan,
   ptdr_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [15:0]      requester_id_ff;
   logic             csr_write;
   logic             push;
   logic             pop;
   job_type          push_job;
   job_type          head_job;
   queue_status_type q_status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         requester_id_ff <= '0;
      end else if (csr_write && (paddr[CSR_ADDR_W-1:2] == CSR_REQUESTER_ID)) begin
         requester_id_ff <= pwdata[15:0];
      end
   end

   assign prdata = (paddr[CSR_ADDR_W-1:2] == CSR_REQUESTER_ID) ?
                   {16'd0, requester_id_ff} : 32'd0;

   ptdr_front #(
      .MAX_PACKET_DWORDS (MAX_PACKET_DWORDS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   ptdr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   ptdr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .requester_id (requester_id_ff),
      .q_status     (q_status),
      .head_job     (head_job),
      .pop          (pop),
      .rsp_chan     (rsp_chan)
   );

endmodule

/* rtl/ptdr_checker.sv */
// ----------------------------------------------------------------------------
// ptdr_checker
// Port-level checks on the result channel of the PCIe dword requester.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pcie_tlp_dword_requester_macros.svh"

module ptdr_checker
   import ptdr_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [1:0]       result_kind,
   input logic [31:0]      tx_dword,
   input logic [31:0]      read_data,
   input logic [LEN_W-1:0] rx_length_dwords,
   input logic [1:0]       status,
   input logic             last_of_run
);

   logic        rsp_stall;
   logic        rsp_take;
   logic        tx_shown;
   logic        err_shown;
   logic        tx_clean;
   logic        err_clean;
   logic [79:0] rsp_word;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_take  = rsp_valid && rsp_ready;
   assign tx_shown  = rsp_valid && (result_kind == KIND_TX);
   assign err_shown = rsp_valid && (result_kind == KIND_ERROR);
   assign tx_clean  = (read_data == 32'd0) && (rx_length_dwords == 11'd0) &&
                      (status == STATUS_OK);
   assign err_clean = last_of_run && (tx_dword == 32'd0) && (read_data == 32'd0) &&
                      ((status == STATUS_MISALIGNED) || (status == STATUS_BAD_CPL));
   assign rsp_word  = {result_kind, tx_dword, read_data, rx_length_dwords, status,
                       last_of_run};

   `PTDR_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_word), "stalled result changed")

   `PTDR_ASSERT_IMP(a_tx_clean, tx_shown, tx_clean, "transmit result carries stray fields")

   `PTDR_ASSERT_IMP(a_err_single, err_shown, err_clean, "malformed error result")

   `PTDR_ASSERT_NXT(a_tx_burst, rsp_take && tx_shown && !last_of_run, tx_shown, "TLP burst broken")

endmodule

bind pcie_tlp_dword_requester ptdr_checker u_ptdr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .result_kind      (rsp_chan.result_kind),
   .tx_dword         (rsp_chan.tx_dword),
   .read_data        (rsp_chan.read_data),
   .rx_length_dwords (rsp_chan.rx_length_dwords),
   .status           (rsp_chan.status),
   .last_of_run      (rsp_chan.last_of_run)
);

/* dv/ptdr_tlp_checker.sv */
// ----------------------------------------------------------------------------
// ptdr_tlp_checker
// Watches the request, result and register ports of the PCIe dword
// requester. It predicts the MWr64/MRd64 dwords, the misalignment errors and
// the completion results from the accepted requests, and compares every
// result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptdr_tlp_checker
   import ptdr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   ptdr_req_if                   req_chan,
   ptdr_rsp_if                   rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   input  logic [31:0]           prdata,
   input  logic                  pready,
   output int                    errors,
   output int                    pending
);

   localparam logic [CSR_ADDR_W-1:0] ID_ADDR = {CSR_REQUESTER_ID, 2'b00};
   localparam int RX_CAP = MAX_PACKET_DWORDS_DEF;

   typedef struct packed {
      logic [1:0]       kind;
      logic [31:0]      tx_dword;
      logic [31:0]      read_data;
      logic [LEN_W-1:0] length;
      logic [1:0]       status;
      logic             last;
   } tlp_result_type;

   tlp_result_type results_due[$];

   logic [15:0]           requester_id;
   logic [RX_COUNT_W-1:0] rx_seen;
   logic [31:0]           rx_hdr;
   logic [31:0]           rx_payload;

   function automatic tlp_result_type result_of(input logic [1:0] kind,
                                                input logic [31:0] tx,
                                                input logic [31:0] rd,
                                                input logic [LEN_W-1:0] len,
                                                input logic [1:0] status,
                                                input logic last);
      tlp_result_type r;
      r.kind      = kind;
      r.tx_dword  = tx;
      r.read_data = rd;
      r.length    = len;
      r.status    = status;
      r.last      = last;
      return r;
   endfunction

   function automatic logic [31:0] byte_reverse(input logic [31:0] w);
      logic [31:0] r;
      for (int i = 0; i < 4; i++)
         r[8*i +: 8] = w[8*(3-i) +: 8];
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : watch
      tlp_result_type   want;
      logic [31:0]      head_dw;
      logic [LEN_W-1:0] pkt_size;
      logic [LEN_W-1:0] len_field;
      if (reset) begin
         results_due.delete();
         requester_id = '0;
         rx_seen      = '0;
         rx_hdr       = '0;
         rx_payload   = '0;
         errors       = 0;
      end else begin
         if (psel && penable && pready && paddr == ID_ADDR) begin
            if (pwrite)
               requester_id = pwdata[15:0];
            else
               check_field("prdata", {16'h0000, requester_id}, prdata);
         end

         if (req_chan.valid && req_chan.ready) begin
            case (req_chan.req_type)
               REQ_MEM_WRITE, REQ_MEM_READ: begin
                  if (req_chan.address[1:0] != 2'b00) begin
                     results_due.push_back(result_of(KIND_ERROR, '0, '0, '0,
                                                     STATUS_MISALIGNED, 1'b1));
                  end else begin
                     head_dw = {(req_chan.req_type == REQ_MEM_WRITE) ?
                                HDR_TYPE_MEM_WRITE : HDR_TYPE_MEM_READ, HDR_LENGTH_ONE};
                     results_due.push_back(result_of(KIND_TX, head_dw, '0, '0,
                                                     STATUS_OK, 1'b0));
                     results_due.push_back(result_of(KIND_TX, {requester_id, BYTE_ENABLES},
                                                     '0, '0, STATUS_OK, 1'b0));
                     results_due.push_back(result_of(KIND_TX, req_chan.address[63:32],
                                                     '0, '0, STATUS_OK, 1'b0));
                     results_due.push_back(result_of(KIND_TX, req_chan.address[31:0],
                                                     '0, '0, STATUS_OK,
                                                     req_chan.req_type == REQ_MEM_READ));
                     if (req_chan.req_type == REQ_MEM_WRITE)
                        results_due.push_back(result_of(KIND_TX,
                                                        byte_reverse(req_chan.write_data),
                                                        '0, '0, STATUS_OK, 1'b1));
                  end
               end
               REQ_RX_DWORD: begin
                  // hold the count at the cap, drop dwords beyond it
                  if (rx_seen < RX_CAP) begin
                     if (rx_seen == 0)
                        rx_hdr = req_chan.rx_dword;
                     else if (rx_seen == 3)
                        rx_payload = req_chan.rx_dword;
                     rx_seen = rx_seen + 1'b1;
                  end
                  if (req_chan.rx_last) begin
                     len_field = {1'b0, rx_hdr[9:0]};
                     case (rx_hdr[30:29])
                        2'd0:    pkt_size = 11'd3;
                        2'd1:    pkt_size = 11'd4;
                        2'd2:    pkt_size = 11'd3 + len_field;
                        default: pkt_size = 11'd4 + len_field;
                     endcase
                     if (rx_hdr[31:24] != HDR_TYPE_COMPLETION || rx_seen < MIN_CPL_DWORDS)
                        results_due.push_back(result_of(KIND_ERROR, '0, '0, pkt_size,
                                                        STATUS_BAD_CPL, 1'b1));
                     else
                        results_due.push_back(result_of(KIND_READ_DATA, '0,
                                                        byte_reverse(rx_payload),
                                                        pkt_size, STATUS_OK, 1'b1));
                     rx_seen = '0;
                  end
               end
               default: ;
            endcase
         end

         if (rsp_chan.valid && rsp_chan.ready) begin
            if (results_due.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, got kind %0h tx %0h",
                        $time, rsp_chan.result_kind, rsp_chan.tx_dword);
               errors++;
            end else begin
               want = results_due.pop_front();
               check_field("result_kind", 32'(want.kind), 32'(rsp_chan.result_kind));
               check_field("tx_dword", want.tx_dword, rsp_chan.tx_dword);
               check_field("read_data", want.read_data, rsp_chan.read_data);
               check_field("rx_length_dwords", 32'(want.length),
                           32'(rsp_chan.rx_length_dwords));
               check_field("status", 32'(want.status), 32'(rsp_chan.status));
               check_field("last_of_run", 32'(want.last), 32'(rsp_chan.last_of_run));
            end
         end
      end
      pending <= results_due.size();
   end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives the PCIe dword requester with directed and random memory requests
// and received TLP dwords, writes the requester id between phases and lets
// the checker judge every result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import ptdr_pkg::*;

   localparam int STALL_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 20;
   localparam int ITEMS_PER_PHASE = 82;

   localparam logic [1:0]            REQ_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ID_ADDR    = {CSR_REQUESTER_ID, 2'b00};

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   int errors;
   int pending;

   ptdr_req_if req_chan ();
   ptdr_rsp_if rsp_chan ();

   pcie_tlp_dword_requester dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   ptdr_tlp_checker u_checker (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .errors   (errors),
      .pending  (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_chan.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
   end

   // end the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_req(input logic [1:0] kind, input logic [63:0] addr,
                           input logic [31:0] wdata, input logic [31:0] rxd,
                           input logic rxlast);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.req_type   <= kind;
      req_chan.address    <= addr;
      req_chan.write_data <= wdata;
      req_chan.rx_dword   <= rxd;
      req_chan.rx_last    <= rxlast;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   task automatic send_mem(input logic [1:0] kind, input logic [63:0] addr,
                           input logic [31:0] wdata);
      send_req(kind, addr, wdata, $urandom, 1'($urandom_range(1)));
   endtask

   // header first, payload in the fourth dword, last flag on the final one
   task automatic send_tlp(input logic [31:0] hdr, input int ndw, input logic [31:0] payload);
      logic [31:0] dw;
      for (int i = 0; i < ndw; i++) begin
         dw = (i == 0) ? hdr : (i == 3) ? payload : $urandom;
         send_req(REQ_RX_DWORD, rand64(), $urandom, dw, i == ndw - 1);
      end
   endtask

   task automatic csr_access(input logic wr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= ID_ADDR;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int gap, input int hold, input logic [15:0] id);
      logic [31:0] junk;
      logic [63:0] addr;
      logic [31:0] hdr;
      int          done;
      int          pick;
      int          ndw;
      settle();
      junk = $urandom;
      csr_access(1'b1, {junk[31:16], id});
      csr_access(1'b0, '0);
      idle_pct  = gap;
      stall_pct = hold;
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
         pick = $urandom_range(99);
         addr = rand64();
         hdr  = $urandom;
         if (pick < 25) begin
            send_mem(REQ_MEM_WRITE, addr & ~64'h3, $urandom);
            done++;
         end else if (pick < 45) begin
            send_mem(REQ_MEM_READ, addr & ~64'h3, $urandom);
            done++;
         end else if (pick < 52) begin
            addr[1:0] = 2'($urandom_range(3, 1));
            send_mem($urandom_range(1) ? REQ_MEM_READ : REQ_MEM_WRITE, addr, $urandom);
            done++;
         end else if (pick < 55) begin
            send_mem(REQ_UNUSED, addr, $urandom);
         end else if (pick < 85) begin
            ndw = $urandom_range(7, 4);
            send_tlp({HDR_TYPE_COMPLETION, hdr[23:0]}, ndw, $urandom);
            done += ndw;
         end else begin
            // broken or foreign TLP: random header, often short
            ndw = $urandom_range(6, 1);
            send_tlp(hdr, ndw, $urandom);
            done += ndw;
         end
      end
   endtask

   initial begin
      reset               <= 1'b1;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.req_type   <= REQ_MEM_WRITE;
      req_chan.address    <= '0;
      req_chan.write_data <= '0;
      req_chan.rx_dword   <= '0;
      req_chan.rx_last    <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // field extremes with the requester id still at its reset value
      send_mem(REQ_MEM_WRITE, 64'h0, 32'h0);
      send_mem(REQ_MEM_WRITE, 64'hFFFF_FFFF_FFFF_FFFC, 32'hFFFF_FFFF);
      send_mem(REQ_MEM_READ, 64'h0, 32'h0);
      send_mem(REQ_MEM_READ, 64'hFFFF_FFFF_FFFF_FFFC, 32'hFFFF_FFFF);
      send_mem(REQ_MEM_WRITE, 64'h0000_0000_0000_0001, 32'h1234_5678);
      send_mem(REQ_MEM_READ, 64'h8000_0000_0000_0002, 32'h0);
      send_mem(REQ_MEM_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 32'hA5A5_5A5A);
      send_mem(REQ_UNUSED, rand64(), $urandom);
      // good completions, short completion, foreign headers of formats 0, 1 and 3
      send_tlp({HDR_TYPE_COMPLETION, 24'h000001}, 4, 32'h1234_5678);
      send_tlp({HDR_TYPE_COMPLETION, 24'h000001}, 3, 32'h0);
      send_tlp(32'h0000_0000, 1, 32'h0);
      send_tlp(32'hFFFF_FFFF, 1, 32'h0);
      send_tlp(32'h2000_0000, 1, 32'h0);
      send_tlp({HDR_TYPE_COMPLETION, 24'h000000}, 5, 32'hFFFF_0000);

      run_phase(0, 0, 16'hFFFF);
      run_phase(71, 0, 16'($urandom_range(65535)));
      run_phase(0, 71, 16'h0000);
      run_phase(28, 28, 16'($urandom_range(65535)));

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
